// ----- rtl/core/dtmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator package
// Shared types, constants and fixed-point helpers for the tone generator.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	localparam int KEY_W    = 8;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int DUR_W    = 10;

	localparam logic [DUR_W-1:0] DUR_RESET = 10'd50;
	localparam int MS_PER_S = 1000;

	// Q15 gain of one, passes a sample unchanged through apply_gain
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;
	localparam logic [GAIN_W-1:0] GAIN_ZERO  = 16'h0000;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint          RSH_OFFSET  = 64'sd1099511627776;

	localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
	localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_TONE,
		KIND_SILENCE
	} kind_t;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_MIX,
		ST_RAMP
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic mix;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] pos;
	} key_hit_t;

	// sine of a 32-bit angle (full turn = 2^32) in Q2.30
	function automatic longint sin_q30(input logic [31:0] ang);
		logic [1:0] quad;
		longint unsigned t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned a;
		longint unsigned s;
		quad = ang[31:30];
		t = {34'd0, ang[29:0]};
		if (quad[0]) begin
			t = Q30_ONE - t;
		end
		x  = (t * Q30_HALF_PI) >> 30;
		x2 = (x * x) >> 30;
		a  = Q30_ONE - x2 / 72;
		a  = Q30_ONE - ((x2 * a) >> 30) / 42;
		a  = Q30_ONE - ((x2 * a) >> 30) / 20;
		a  = Q30_ONE - ((x2 * a) >> 30) / 6;
		s  = (x * a) >> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		return quad[1] ? -$signed(s) : $signed(s);
	endfunction

	// round half up of v / 2^n
	function automatic longint round_shift(input longint v, input int unsigned n);
		longint unsigned u;
		u = $unsigned(v + RSH_OFFSET) + (64'd1 << (n - 1));
		return $signed(u >> n) - (RSH_OFFSET >>> n);
	endfunction

	// scale a Q1.15 sample by a Q15 gain, rounding half up
	function automatic logic signed [SAMPLE_W-1:0] apply_gain(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [GAIN_W-1:0] g
	);
		logic signed [SAMPLE_W+GAIN_W:0] p;
		p = s * $signed({1'b0, g});
		p = p + 33'sd16384;
		return p[SAMPLE_W+14:15];
	endfunction

	// keypad position, row in the upper two bits
	function automatic key_hit_t key_lookup(input logic [KEY_W-1:0] key);
		key_hit_t r;
		r.hit = 1'b1;
		case (key)
			"1": r.pos = 4'd0;
			"2": r.pos = 4'd1;
			"3": r.pos = 4'd2;
			"A": r.pos = 4'd3;
			"4": r.pos = 4'd4;
			"5": r.pos = 4'd5;
			"6": r.pos = 4'd6;
			"B": r.pos = 4'd7;
			"7": r.pos = 4'd8;
			"8": r.pos = 4'd9;
			"9": r.pos = 4'd10;
			"C": r.pos = 4'd11;
			"*": r.pos = 4'd12;
			"0": r.pos = 4'd13;
			"#": r.pos = 4'd14;
			"D": r.pos = 4'd15;
			default: begin
				r.hit = 1'b0;
				r.pos = 4'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_pause(input logic [KEY_W-1:0] key);
		return (key == " ") || (key == ",") || (key == "-");
	endfunction

endpackage

// ----- rtl/core/dtmf_seglen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF segment length unit
// Holds the duration register and turns it into a sample count through a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module dtmf_seglen #(
	parameter int SAMPLE_RATE = 8000,
	parameter int MAX_SEGMENT = 16384,
	localparam int LW = $clog2(MAX_SEGMENT + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dtmf_pkg::DUR_W-1:0] cfg_wdata,
	output logic [LW-1:0]              len,
	output logic                       len_ok
);

	localparam int SRW = $clog2(SAMPLE_RATE + 1);
	localparam int PW  = dtmf_pkg::DUR_W + SRW;
	localparam int K   = PW + 10;
	localparam int MW  = K - 9;
	localparam int QW  = PW - 9;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << K) / dtmf_pkg::MS_PER_S);

	logic [dtmf_pkg::DUR_W-1:0] dur_q;
	logic [1:0]                 settle_q;
	logic [PW-1:0]              p_s1;
	logic [PW-1:0]              p_s2;
	logic [QW-1:0]              q_s2;
	logic [LW-1:0]              len_q;
	logic [PW+MW-1:0]           qprod;
	logic [PW-1:0]              q_scaled;
	logic [PW-1:0]              rem;
	logic [QW:0]                q_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q    <= dtmf_pkg::DUR_RESET;
			settle_q <= 2'd3;
		end else if (cfg_we) begin
			dur_q    <= cfg_wdata;
			settle_q <= 2'd3;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign qprod    = (PW+MW)'(p_s1) * (PW+MW)'(RECIP);
	assign q_scaled = PW'(q_s2) * PW'(dtmf_pkg::MS_PER_S);
	assign rem      = p_s2 - q_scaled;
	assign q_fix    = {1'b0, q_s2} + ((rem >= PW'(dtmf_pkg::MS_PER_S)) ? (QW+1)'(1) : '0);

	always_ff @(posedge clk) begin
		p_s1 <= PW'(dur_q) * PW'(SAMPLE_RATE);
		p_s2 <= p_s1;
		q_s2 <= qprod[PW+MW-1 -: QW];
		if (32'(q_fix) > 32'(MAX_SEGMENT)) begin
			len_q <= LW'(MAX_SEGMENT);
		end else if (q_fix == '0) begin
			len_q <= LW'(1);
		end else begin
			len_q <= LW'(q_fix);
		end
	end

	assign len    = len_q;
	assign len_ok = (settle_q == 2'd0);

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_ok |-> (len != '0) && (32'(len) <= 32'(MAX_SEGMENT)))
		else $error("segment length out of range");

endmodule

// ----- rtl/core/dtmf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF controller
// Sequences one sample request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module dtmf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           func,
	input  logic           len_ok,
	input  logic           m_tready,
	output logic           s_tready,
	output logic           m_tvalid,
	output dtmf_pkg::cmd_t cmd
);

	dtmf_pkg::state_t state_q;
	dtmf_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dtmf_pkg::ST_WAIT: begin
				if (accept && func) begin
					state_d = dtmf_pkg::ST_MIX;
				end
			end
			dtmf_pkg::ST_MIX: begin
				state_d = dtmf_pkg::ST_RAMP;
			end
			dtmf_pkg::ST_RAMP: begin
				if (out_free) begin
					state_d = dtmf_pkg::ST_WAIT;
				end
			end
			default: begin
				state_d = dtmf_pkg::ST_WAIT;
			end
		endcase
	end

	always_comb begin
		s_tready  = (state_q == dtmf_pkg::ST_WAIT) && len_ok;
		cmd.start = s_tvalid && s_tready && !func;
		cmd.step  = s_tvalid && s_tready && func;
		cmd.mix   = (state_q == dtmf_pkg::ST_MIX);
		cmd.load  = (state_q == dtmf_pkg::ST_RAMP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtmf_pkg::ST_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func) |=> (state_q == dtmf_pkg::ST_MIX))
		else $error("sample request did not enter the mix stage");

	a_mix_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtmf_pkg::ST_MIX) |=> (state_q == dtmf_pkg::ST_RAMP) && !s_tready)
		else $error("mix stage did not advance to ramp stage");

endmodule

// ----- rtl/core/dtmf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF datapath
// Segment sequencing state, phase accumulators, sine and ramp tables, the two
// gain stages and the output register.
// ----------------------------------------------------------------------------
module dtmf_dp #(
	parameter int SAMPLE_RATE      = 8000,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int MAX_SEGMENT      = 16384,
	localparam int LW = $clog2(MAX_SEGMENT + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dtmf_pkg::cmd_t                       cmd,
	input  logic [dtmf_pkg::KEY_W-1:0]           key,
	input  logic [LW-1:0]                        len,
	output logic signed [dtmf_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last,
	output logic                                 idle
);

	localparam int IW    = $clog2(SINE_TABLE_DEPTH);
	localparam int PRW   = 32 + IW;
	localparam int RAMP  = SAMPLE_RATE * 4 / 1000;
	localparam int RAMP2 = 2 * RAMP;
	localparam int RW    = $clog2(RAMP + 1);

	typedef logic signed [dtmf_pkg::SAMPLE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
	typedef logic [dtmf_pkg::GAIN_W-1:0] ramp_rom_t [2**RW];

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		longint unsigned ang;
		longint v;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			ang = (64'(k) << 32) / SINE_TABLE_DEPTH;
			v = dtmf_pkg::round_shift(dtmf_pkg::sin_q30(32'(ang)), 15);
			if (v > 64'sd32767) begin
				v = 64'sd32767;
			end
			if (v < -64'sd32767) begin
				v = -64'sd32767;
			end
			rom[k] = dtmf_pkg::SAMPLE_W'(v);
		end
		return rom;
	endfunction

	// raised-cosine gain 0.5*(1 - cos(pi*k/RAMP)), Q15
	function automatic ramp_rom_t build_ramp();
		ramp_rom_t rom;
		longint unsigned ang;
		longint c;
		for (int k = 0; k < 2**RW; k++) begin
			if (k <= RAMP) begin
				ang = ((64'(k) << 32) / RAMP2) + 64'h4000_0000;
				c = dtmf_pkg::sin_q30(32'(ang));
				rom[k] = dtmf_pkg::GAIN_W'(
					dtmf_pkg::round_shift($signed(dtmf_pkg::Q30_ONE) - c, 16));
			end else begin
				rom[k] = '0;
			end
		end
		return rom;
	endfunction

	function automatic logic [31:0] phase_incr(input int unsigned hz);
		return 32'(((64'(hz) << 32) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE);
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();
	localparam ramp_rom_t RAMP_ROM = build_ramp();

	localparam logic [31:0] ROW_INC [4] = '{
		phase_incr(dtmf_pkg::ROW_HZ[0]), phase_incr(dtmf_pkg::ROW_HZ[1]),
		phase_incr(dtmf_pkg::ROW_HZ[2]), phase_incr(dtmf_pkg::ROW_HZ[3])};
	localparam logic [31:0] COL_INC [4] = '{
		phase_incr(dtmf_pkg::COL_HZ[0]), phase_incr(dtmf_pkg::COL_HZ[1]),
		phase_incr(dtmf_pkg::COL_HZ[2]), phase_incr(dtmf_pkg::COL_HZ[3])};

	// sequencing state
	dtmf_pkg::kind_t kind_q;
	logic [31:0]     row_phase_q;
	logic [31:0]     col_phase_q;
	logic [LW-1:0]   count_q;
	logic [1:0]      row_idx_q;
	logic [1:0]      col_idx_q;
	logic            left_q;

	// sample pipeline
	logic signed [dtmf_pkg::SAMPLE_W-1:0] row_s1;
	logic signed [dtmf_pkg::SAMPLE_W-1:0] col_s1;
	logic [dtmf_pkg::GAIN_W-1:0]          g1_s1;
	logic [dtmf_pkg::GAIN_W-1:0]          g2_s1;
	logic                                 last_s1;
	logic                                 idle_s1;
	logic signed [dtmf_pkg::SAMPLE_W-1:0] mix_s2;
	logic [dtmf_pkg::GAIN_W-1:0]          g2_s2;
	logic                                 last_s2;
	logic                                 idle_s2;
	logic signed [dtmf_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 last_q;
	logic                                 idle_q;

	dtmf_pkg::key_hit_t                   hit;
	logic [PRW-1:0]                       row_prod;
	logic [PRW-1:0]                       col_prod;
	logic [IW-1:0]                        row_addr;
	logic [IW-1:0]                        col_addr;
	logic [LW-1:0]                        count_inc;
	logic                                 seg_done;
	logic [LW-1:0]                        rem;
	logic                                 use1;
	logic                                 use2;
	logic [dtmf_pkg::GAIN_W-1:0]          g1;
	logic [dtmf_pkg::GAIN_W-1:0]          g2;
	logic signed [dtmf_pkg::SAMPLE_W:0]   tone_sum;

	assign hit       = dtmf_pkg::key_lookup(key);
	assign row_prod  = PRW'(row_phase_q) * PRW'(SINE_TABLE_DEPTH);
	assign col_prod  = PRW'(col_phase_q) * PRW'(SINE_TABLE_DEPTH);
	assign row_addr  = row_prod[PRW-1:32];
	assign col_addr  = col_prod[PRW-1:32];
	assign count_inc = count_q + LW'(1);
	assign seg_done  = (count_inc >= len);
	assign rem       = len - LW'(1) - count_q;
	assign use1      = (count_q < LW'(RAMP));
	assign use2      = (count_q < len) && (rem < LW'(RAMP));

	// silence and idle requests run through with zero gain
	always_comb begin
		if (kind_q != dtmf_pkg::KIND_TONE) begin
			g1 = dtmf_pkg::GAIN_ZERO;
		end else if (use1) begin
			g1 = RAMP_ROM[count_q[RW-1:0]];
		end else begin
			g1 = dtmf_pkg::GAIN_UNITY;
		end
		g2 = use2 ? RAMP_ROM[rem[RW-1:0]] : dtmf_pkg::GAIN_UNITY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= dtmf_pkg::KIND_IDLE;
			row_phase_q <= '0;
			col_phase_q <= '0;
			count_q     <= '0;
			row_idx_q   <= '0;
			col_idx_q   <= '0;
			left_q      <= 1'b0;
		end else if (cmd.start) begin
			// drop a start while a sequence plays
			if (kind_q == dtmf_pkg::KIND_IDLE) begin
				row_phase_q <= '0;
				col_phase_q <= '0;
				count_q     <= '0;
				if (hit.hit) begin
					row_idx_q <= hit.pos[3:2];
					col_idx_q <= hit.pos[1:0];
					kind_q    <= dtmf_pkg::KIND_TONE;
					left_q    <= 1'b1;
				end else if (dtmf_pkg::is_pause(key)) begin
					kind_q <= dtmf_pkg::KIND_SILENCE;
					left_q <= 1'b1;
				end else begin
					kind_q <= dtmf_pkg::KIND_SILENCE;
					left_q <= 1'b0;
				end
			end
		end else if (cmd.step && kind_q != dtmf_pkg::KIND_IDLE) begin
			if (kind_q == dtmf_pkg::KIND_TONE) begin
				row_phase_q <= row_phase_q + ROW_INC[row_idx_q];
				col_phase_q <= col_phase_q + COL_INC[col_idx_q];
			end
			if (seg_done) begin
				count_q <= '0;
				if (left_q) begin
					left_q <= 1'b0;
					kind_q <= dtmf_pkg::KIND_SILENCE;
				end else begin
					kind_q <= dtmf_pkg::KIND_IDLE;
				end
			end else begin
				count_q <= count_inc;
			end
		end
	end

	assign tone_sum = {row_s1[dtmf_pkg::SAMPLE_W-1], row_s1}
		+ {col_s1[dtmf_pkg::SAMPLE_W-1], col_s1};

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			row_s1  <= SINE_ROM[row_addr];
			col_s1  <= SINE_ROM[col_addr];
			g1_s1   <= g1;
			g2_s1   <= g2;
			last_s1 <= (kind_q != dtmf_pkg::KIND_IDLE) && seg_done && !left_q;
			idle_s1 <= (kind_q == dtmf_pkg::KIND_IDLE);
		end
		if (cmd.mix) begin
			mix_s2  <= dtmf_pkg::apply_gain(tone_sum[dtmf_pkg::SAMPLE_W:1], g1_s1);
			g2_s2   <= g2_s1;
			last_s2 <= last_s1;
			idle_s2 <= idle_s1;
		end
		if (cmd.load) begin
			sample_q <= dtmf_pkg::apply_gain(mix_s2, g2_s2);
			last_q   <= last_s2;
			idle_q   <= idle_s2;
		end
	end

	assign sample = sample_q;
	assign last   = last_q;
	assign idle   = idle_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == dtmf_pkg::KIND_IDLE) |-> (count_q == '0) && !left_q)
		else $error("idle with a segment still counted or queued");

	a_tone_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == dtmf_pkg::KIND_TONE) |-> left_q)
		else $error("tone segment without a trailing silence");

endmodule

// ----- rtl/core/dtmf_tone_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator
// Plays one dialing character as tone and silence segments, one Q1.15 sample
// per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects the item kind (0 starts the character in
//   tdata, 1 requests the next sample). A start returns nothing; a start
//   while a character plays is dropped.
//   Output stream: one transfer per sample request; tdata is the sample,
//   tlast marks the final sample of the character, tuser flags idle.
//   The block takes no new sample request until the previous one has
//   passed the table read and the two ramp multiplier stages after it.
//   A single output register holds a finished sample; the block takes the
//   next item while it waits, and a second request stops in the last gain
//   stage until the receiver drains the register.
//   Reset: duration is 50 ms, no character is playing, and tready stays low
//   while the segment length is computed. A write to cfg_wdata repeats
//   that settle.
// ----------------------------------------------------------------------------
module dtmf_tone_generator #(
	parameter int SAMPLE_RATE      = 8000,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int MAX_SEGMENT      = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dtmf_pkg::DUR_W-1:0]          cfg_wdata,     // duration_ms
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dtmf_pkg::KEY_W-1:0]          s_axis_tdata,  // [7:0] key
	input  logic                                s_axis_tuser,  // [0] func
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dtmf_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] sample
	output logic                                m_axis_tlast,
	output logic                                m_axis_tuser   // [0] idle
);

	localparam int LW = $clog2(MAX_SEGMENT + 1);

	logic [LW-1:0]                        len;
	logic                                 len_ok;
	dtmf_pkg::cmd_t                       cmd;
	logic signed [dtmf_pkg::SAMPLE_W-1:0] sample;

	dtmf_seglen #(
		.SAMPLE_RATE (SAMPLE_RATE),
		.MAX_SEGMENT (MAX_SEGMENT)
	) u_seglen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.len       (len),
		.len_ok    (len_ok)
	);

	dtmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.func     (s_axis_tuser),
		.len_ok   (len_ok),
		.m_tready (m_axis_tready),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.cmd      (cmd)
	);

	dtmf_dp #(
		.SAMPLE_RATE      (SAMPLE_RATE),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.MAX_SEGMENT      (MAX_SEGMENT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (s_axis_tdata),
		.len    (len),
		.sample (sample),
		.last   (m_axis_tlast),
		.idle   (m_axis_tuser)
	);

	assign m_axis_tdata = sample;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator testbench
// Dials keypad, pause and stray characters into the generator and pulls
// samples back. A scoreboard tracks the phase accumulators, segment counter
// and ramp gains, and compares each output transfer with the next expected
// sample. The segment length is changed between phases, also while a
// character is still playing, over the full range of the register.
// ----------------------------------------------------------------------------
module testbench;

	typedef longint unsigned u64_t;

	localparam int RATE           = 8000;
	localparam int LUT_DEPTH      = 1024;
	localparam int SEG_CAP        = 16384;
	localparam int FADE_LEN       = (RATE * 4) / 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 145;

	localparam bit [7:0] KEYPAD [16] = '{"1", "2", "3", "A", "4", "5", "6", "B",
		"7", "8", "9", "C", "*", "0", "#", "D"};
	localparam bit [7:0] PAUSE_KEYS [3] = '{" ", ",", "-"};
	localparam int unsigned ROW_FREQ [4] = '{697, 770, 852, 941};
	localparam int unsigned COL_FREQ [4] = '{1209, 1336, 1477, 1633};
	localparam bit [dtmf_pkg::DUR_W-1:0] PHASE_MS [10] =
		'{1, 4, 0, 2, 1000, 7, 5, 1023, 3, 1};

	typedef struct {
		logic [dtmf_pkg::SAMPLE_W-1:0] sample;
		logic                          last;
		logic                          idle;
	} sample_t;

	class dtmf_scoreboard;
		int sine_lut [LUT_DEPTH];
		int fade_lut [FADE_LEN+1];
		bit [31:0] row_step [4];
		bit [31:0] col_step [4];
		bit [dtmf_pkg::DUR_W-1:0] duration;
		bit [31:0] row_acc;
		bit [31:0] col_acc;
		bit [14:0] seg_pos;
		dtmf_pkg::kind_t seg_kind;
		bit [1:0] row_sel;
		bit [1:0] col_sel;
		bit [1:0] segs_queued;
		sample_t expected_samples [$];
		int mismatches;
		int checked;

		function new();
			longint v;
			int k;
			for (k = 0; k < LUT_DEPTH; k++) begin
				v = rounded_shift(sin_q30_of(32'((u64_t'(k) << 32) / LUT_DEPTH)), 15);
				if (v > 32767) v = 32767;
				if (v < -32767) v = -32767;
				sine_lut[k] = int'(v);
			end
			// raised cosine from the cosine of half a turn across the ramp
			for (k = 0; k <= FADE_LEN; k++) begin
				v = sin_q30_of(32'((u64_t'(k) << 32) / (2 * FADE_LEN)) + 32'h4000_0000);
				fade_lut[k] = int'(rounded_shift(longint'(u64_t'(1) << 30) - v, 16));
			end
			for (k = 0; k < 4; k++) begin
				row_step[k] = 32'(((u64_t'(ROW_FREQ[k]) << 32) + RATE / 2) / RATE);
				col_step[k] = 32'(((u64_t'(COL_FREQ[k]) << 32) + RATE / 2) / RATE);
			end
			duration    = dtmf_pkg::DUR_RESET;
			row_acc     = '0;
			col_acc     = '0;
			seg_pos     = '0;
			seg_kind    = dtmf_pkg::KIND_IDLE;
			row_sel     = '0;
			col_sel     = '0;
			segs_queued = '0;
			mismatches  = 0;
			checked     = 0;
		endfunction

		static function longint rounded_shift(input longint v, input int n);
			return (v + (longint'(1) <<< (n - 1))) >>> n;
		endfunction

		// Taylor series of sine in Q2.30, folded to the first quadrant
		static function longint sin_q30_of(input bit [31:0] angle);
			u64_t one;
			u64_t frac;
			u64_t x;
			u64_t x2;
			u64_t acc;
			u64_t s;
			int unsigned divs [4];
			one  = u64_t'(1) << 30;
			divs = '{72, 42, 20, 6};
			frac = angle[29:0];
			if (angle[30]) frac = one - frac;
			x   = (frac * 64'd1686629713) >> 30;
			x2  = (x * x) >> 30;
			acc = one;
			foreach (divs[i]) acc = one - ((x2 * acc) >> 30) / divs[i];
			s = (x * acc) >> 30;
			if (s > one) s = one;
			return angle[31] ? -longint'(s) : longint'(s);
		endfunction

		function int faded(input int s, input int g);
			return int'(rounded_shift(longint'(s) * g, 15));
		endfunction

		function bit busy();
			return seg_kind != dtmf_pkg::KIND_IDLE;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		// advance the generator state by one accepted input transfer
		function void advance_dial(input bit fn, input bit [7:0] key);
			int pad_pos;
			int seg_len;
			int at;
			int s;
			sample_t e;
			if (!fn) begin
				if (seg_kind != dtmf_pkg::KIND_IDLE) return;
				pad_pos = -1;
				foreach (KEYPAD[i]) if (KEYPAD[i] == key && pad_pos < 0) pad_pos = i;
				row_acc = '0;
				col_acc = '0;
				seg_pos = '0;
				if (pad_pos >= 0) begin
					row_sel     = 2'(pad_pos / 4);
					col_sel     = 2'(pad_pos % 4);
					seg_kind    = dtmf_pkg::KIND_TONE;
					segs_queued = 2'd1;
				end else if (key == " " || key == "," || key == "-") begin
					seg_kind    = dtmf_pkg::KIND_SILENCE;
					segs_queued = 2'd1;
				end else begin
					seg_kind    = dtmf_pkg::KIND_SILENCE;
					segs_queued = 2'd0;
				end
				return;
			end
			e.sample = '0;
			e.last   = 1'b0;
			e.idle   = 1'b0;
			if (seg_kind == dtmf_pkg::KIND_IDLE) begin
				e.idle = 1'b1;
				expected_samples.push_back(e);
				return;
			end
			seg_len = int'(duration) * RATE / 1000;
			if (seg_len > SEG_CAP) seg_len = SEG_CAP;
			if (seg_len == 0) seg_len = 1;
			at = seg_pos;
			s  = 0;
			if (seg_kind == dtmf_pkg::KIND_TONE) begin
				s = (sine_lut[(u64_t'(row_acc) * LUT_DEPTH) >> 32]
					+ sine_lut[(u64_t'(col_acc) * LUT_DEPTH) >> 32]) >>> 1;
				if (at < FADE_LEN) s = faded(s, fade_lut[at]);
				if (at < seg_len && seg_len - 1 - at < FADE_LEN)
					s = faded(s, fade_lut[seg_len - 1 - at]);
				row_acc += row_step[row_sel];
				col_acc += col_step[col_sel];
			end
			seg_pos = 15'(at + 1);
			if (seg_pos >= seg_len) begin
				seg_pos = '0;
				if (segs_queued > 0) begin
					segs_queued--;
					seg_kind = dtmf_pkg::KIND_SILENCE;
				end else begin
					seg_kind = dtmf_pkg::KIND_IDLE;
					e.last   = 1'b1;
				end
			end
			e.sample = 16'(s);
			expected_samples.push_back(e);
		endfunction

		function void check_sample(input logic [dtmf_pkg::SAMPLE_W-1:0] smp,
			input logic lst, input logic idl);
			sample_t e;
			checked++;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample %0d last %b idle %b", $time, $signed(smp),
					lst, idl);
				mismatches++;
				return;
			end
			e = expected_samples.pop_front();
			if (smp !== e.sample) begin
				$display("%0t: sample expected %0d got %0d", $time, $signed(e.sample),
					$signed(smp));
				mismatches++;
			end
			if (lst !== e.last) begin
				$display("%0t: last expected %b got %b", $time, e.last, lst);
				mismatches++;
			end
			if (idl !== e.idle) begin
				$display("%0t: idle expected %b got %b", $time, e.idle, idl);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [dtmf_pkg::DUR_W-1:0]    cfg_wdata = '0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [dtmf_pkg::KEY_W-1:0]    s_axis_tdata = '0;
	logic                          s_axis_tuser = 1'b0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [dtmf_pkg::SAMPLE_W-1:0] m_axis_tdata;
	logic                          m_axis_tlast;
	logic                          m_axis_tuser;

	dtmf_scoreboard sb;
	bit steady = 1'b0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int starts_sent = 0;
	int lengths_used = 0;

	dtmf_tone_generator #(
		.SAMPLE_RATE(RATE),
		.SINE_TABLE_DEPTH(LUT_DEPTH),
		.MAX_SEGMENT(SEG_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_item(input bit fn, input bit [7:0] key);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= key;
		s_axis_tuser  <= fn;
		do @(posedge clk); while (!s_axis_tready);
		sb.advance_dial(fn, key);
		items_sent++;
		if (!fn) starts_sent++;
	endtask

	// hold the input until every sample is back, then let any start settle
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_duration(input bit [dtmf_pkg::DUR_W-1:0] ms);
		cfg_we    <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.duration = ms;
		lengths_used++;
	endtask

	function automatic bit [7:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return KEYPAD[$urandom_range(0, 15)];
		if (roll < 72) return PAUSE_KEYS[$urandom_range(0, 2)];
		if (roll < 80) return 8'("a" + $urandom_range(0, 3));
		if (roll < 82) return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly whole characters played out, with stray requests and dropped starts
	task automatic dial_phase(input int budget);
		int count;
		int roll;
		count = 0;
		while (count < budget) begin
			roll = $urandom_range(0, 99);
			if (!sb.busy()) begin
				if (roll < 12) send_item(1'b1, 8'($urandom_range(0, 255)));
				else send_item(1'b0, pick_key());
				count++;
			end else if (roll < 4) begin
				send_item(1'b0, 8'($urandom_range(0, 255)));
			end else begin
				send_item(1'b1, 8'($urandom_range(0, 255)));
				count++;
			end
			if ($urandom_range(0, 63) == 0) drain_outputs();
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_sample(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset length, request while idle, dropped start mid-tone
		send_item(1'b1, 8'hA5);
		send_item(1'b0, "5");
		repeat (3) send_item(1'b1, 8'h00);
		send_item(1'b0, "9");
		repeat (2) send_item(1'b1, 8'hFF);
		// shrink to zero length while the tone plays: it ends on the next sample
		drain_outputs();
		set_duration(10'd0);
		repeat (3) send_item(1'b1, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h00);
		send_item(1'b0, " ");
		repeat (2) send_item(1'b1, 8'h00);
		send_item(1'b0, "a");
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b1, 8'h00);
		send_item(1'b0, "#");
		repeat (2) send_item(1'b1, 8'h00);

		foreach (PHASE_MS[i]) begin
			drain_outputs();
			steady = ($urandom_range(0, 3) == 0);
			set_duration(PHASE_MS[i]);
			dial_phase(PHASE_ITEMS);
		end
		steady = 1'b0;
		drain_outputs();

		$display("Sent %0d input transfers (%0d starts) over %0d segment lengths,",
			items_sent, starts_sent, lengths_used + 1);
		$display("checked %0d samples across keypad, pause and stray characters.",
			sb.checked);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/dtmf_pkg.sv
rtl/core/dtmf_seglen.sv
rtl/core/dtmf_ctrl.sv
rtl/core/dtmf_dp.sv
rtl/core/dtmf_tone_generator.sv
sim/testbench.sv
